// ===== rtl/core/midi_basic_channel_group_table_macros.svh =====
// Assertion macros for the MIDI basic-channel group table
`ifndef MIDI_BASIC_CHANNEL_GROUP_TABLE_MACROS_SVH
`define MIDI_BASIC_CHANNEL_GROUP_TABLE_MACROS_SVH

// Clocked assertion, disabled during reset
`define MBCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked also during reset
`define MBCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mbcg_pkg.sv =====
// Types and constants for the MIDI basic-channel group table
package mbcg_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CH_W         = 4;
  localparam int CNT_W        = 5;
  localparam int CFG_AW       = 3;

  localparam logic [1:0] ACT_SET       = 2'd0;
  localparam logic [1:0] ACT_RESET_GRP = 2'd1;
  localparam logic [1:0] ACT_RESET_ALL = 2'd2;
  localparam logic [1:0] ACT_QUERY     = 2'd3;

  localparam logic [1:0] MODE_OFF_POLY = 2'd2;

  localparam logic [CFG_AW-1:0] REG_CHANNEL_COUNT = 3'd0;

  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [1:0]       action;
    logic [CH_W-1:0]  channel;
    logic [1:0]       mode;
    logic [CNT_W-1:0] group_size;
    logic             allow_change;
  } mbcg_in_t;

  typedef struct packed {
    logic             status;
    logic             basic_valid;
    logic [CH_W-1:0]  owner_channel;
    logic [1:0]       channel_mode;
    logic [CNT_W-1:0] group_count;
    logic [15:0]      notes_off_mask;
  } mbcg_out_t;

  // Saturate a range end to the table depth
  function automatic logic [CNT_W-1:0] sat_end(input logic [CNT_W:0] v);
    logic [CNT_W-1:0] r;
    if (v > (CNT_W+1)'(MAX_CHANNELS)) begin
      r = CNT_W'(MAX_CHANNELS);
    end else begin
      r = v[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/midi_basic_channel_group_table.sv =====
// MIDI basic-channel group table: sequencer walking the channel entries one per cycle
// Set group runs check, overlap scan, clear of the old group and write; reset group
// runs check and clear, reset all clear, query check and scan; a failed check ends it.
// Throughput: one item at a time; the entry walk (one entry read or written per cycle) sets it.
// Reset: synchronous active-low rst_n clears basic and enabled flags, sets channel_count to 16.
// Results wait in an output register, so a new item is taken while one is pending.
`include "midi_basic_channel_group_table_macros.svh"

module midi_basic_channel_group_table
  import mbcg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mbcg_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mbcg_out_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_QSCAN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        ccount_r;
  logic [MAX_CHANNELS-1:0] basic_r, enabled_r;
  logic [1:0]              mode_mem [MAX_CHANNELS];
  logic [CNT_W-1:0]        gs_mem [MAX_CHANNELS];

  logic [1:0]       act_r, act_nxt;
  logic [CH_W-1:0]  c_r, c_nxt;
  logic [1:0]       opm_r, opm_nxt;
  logic [CNT_W-1:0] req_r, req_nxt;
  logic             allow_r, allow_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] size_r, size_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic             basic_c_r, basic_c_nxt;
  logic [CNT_W-1:0] gs_c_r, gs_c_nxt;
  logic [1:0]       mode_c_r, mode_c_nxt;
  logic             fail_r, fail_nxt;
  logic             qv_r, qv_nxt;
  logic [CH_W-1:0]  owner_r, owner_nxt;
  logic [1:0]       omode_r, omode_nxt;
  logic [CNT_W-1:0] ocount_r, ocount_nxt;
  logic [15:0]      mask_r, mask_nxt;
  logic             out_valid_r, out_valid_nxt;
  mbcg_out_t        out_data_r, out_data_nxt;

  logic [CH_W-1:0]  rd_idx;
  logic             rd_basic, rd_en;
  logic [1:0]       rd_mode;
  logic [CNT_W-1:0] rd_gs;
  logic             wr_en, wr_fill;
  logic             cfg_wr;
  logic             in_fire;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_AW-1:2] == REG_CHANNEL_COUNT[CFG_AW-1:2]);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_CHANNEL_COUNT[CFG_AW-1:2]) ?
                      {27'd0, ccount_r} : 32'd0;

  assign rd_idx   = (state_r == ST_CHECK) ? c_r : k_r[CH_W-1:0];
  assign rd_basic = basic_r[rd_idx];
  assign rd_en    = enabled_r[rd_idx];
  assign rd_mode  = mode_mem[rd_idx];
  assign rd_gs    = gs_mem[rd_idx];

  always_comb begin
    logic [CNT_W:0]   sum_req;
    logic [CNT_W-1:0] size_calc;
    logic [CNT_W-1:0] post_size;
    logic             go_post;
    state_nxt   = state_r;
    act_nxt     = act_r;
    c_nxt       = c_r;
    opm_nxt     = opm_r;
    req_nxt     = req_r;
    allow_nxt   = allow_r;
    n_nxt       = n_r;
    size_nxt    = size_r;
    k_nxt       = k_r;
    end_nxt     = end_r;
    basic_c_nxt = basic_c_r;
    gs_c_nxt    = gs_c_r;
    mode_c_nxt  = mode_c_r;
    fail_nxt    = fail_r;
    qv_nxt      = qv_r;
    owner_nxt   = owner_r;
    omode_nxt   = omode_r;
    ocount_nxt  = ocount_r;
    mask_nxt    = mask_r;
    wr_en       = 1'b0;
    wr_fill     = 1'b0;
    go_post     = 1'b0;
    post_size   = size_r;
    sum_req     = {2'b00, c_r} + {1'b0, req_r};
    if (opm_r == MODE_OFF_POLY) begin
      size_calc = CNT_W'(1);
    end else if (req_r == '0) begin
      size_calc = n_r - {1'b0, c_r};
    end else begin
      size_calc = req_r;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_data.action;
          c_nxt     = in_data.channel;
          opm_nxt   = in_data.mode;
          req_nxt   = in_data.group_size;
          allow_nxt = in_data.allow_change;
          n_nxt     = sat_end({1'b0, ccount_r});
          fail_nxt  = 1'b0;
          qv_nxt    = 1'b0;
          owner_nxt = '0;
          omode_nxt = '0;
          ocount_nxt = '0;
          mask_nxt  = '0;
          if (in_data.action == ACT_RESET_ALL) begin
            k_nxt     = '0;
            end_nxt   = sat_end({1'b0, ccount_r});
            state_nxt = ST_CLEAR;
          end else if ({1'b0, in_data.channel} >= sat_end({1'b0, ccount_r})) begin
            fail_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        basic_c_nxt = rd_basic;
        gs_c_nxt    = rd_gs;
        mode_c_nxt  = rd_mode;
        k_nxt       = {1'b0, c_r};
        case (act_r)
          ACT_SET: begin
            if (opm_r != MODE_OFF_POLY && req_r != '0 && sum_req > {1'b0, n_r}) begin
              fail_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else if (rd_en && !(rd_basic && allow_r)) begin
              fail_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              size_nxt  = size_calc;
              k_nxt     = {1'b0, c_r} + CNT_W'(1);
              end_nxt   = sat_end({2'b00, c_r} + {1'b0, size_calc});
              state_nxt = ST_SCAN;
            end
          end
          ACT_RESET_GRP: begin
            if (!rd_basic) begin
              fail_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              end_nxt   = sat_end({2'b00, c_r} + {1'b0, rd_gs});
              state_nxt = ST_CLEAR;
            end
          end
          default: begin
            state_nxt = rd_en ? ST_QSCAN : ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        if (k_r >= end_r) begin
          go_post = 1'b1;
        end else if (rd_basic) begin
          if (req_r == '0 && opm_r != MODE_OFF_POLY) begin
            post_size = k_r - {1'b0, c_r};
            size_nxt  = post_size;
            go_post   = 1'b1;
          end else begin
            fail_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
        if (go_post) begin
          k_nxt = {1'b0, c_r};
          if (basic_c_r) begin
            end_nxt   = sat_end({2'b00, c_r} + {1'b0, gs_c_r});
            state_nxt = ST_CLEAR;
          end else begin
            end_nxt   = sat_end({2'b00, c_r} + {1'b0, post_size});
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_CLEAR: begin
        if (k_r >= end_r) begin
          if (act_r == ACT_SET) begin
            k_nxt     = {1'b0, c_r};
            end_nxt   = sat_end({2'b00, c_r} + {1'b0, size_r});
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          wr_en = 1'b1;
          k_nxt = k_r + CNT_W'(1);
        end
      end
      ST_WRITE: begin
        if (k_r >= end_r) begin
          state_nxt = ST_DONE;
        end else begin
          wr_en    = 1'b1;
          wr_fill  = 1'b1;
          mask_nxt = mask_r | (16'd1 << k_r[CH_W-1:0]);
          k_nxt    = k_r + CNT_W'(1);
        end
      end
      ST_QSCAN: begin
        if (rd_basic) begin
          qv_nxt     = 1'b1;
          owner_nxt  = k_r[CH_W-1:0];
          omode_nxt  = mode_c_r;
          ocount_nxt = rd_gs;
          state_nxt  = ST_DONE;
        end else if (k_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt = k_r - CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = fail_r;
          out_data_nxt.basic_valid     = qv_r;
          out_data_nxt.owner_channel   = owner_r;
          out_data_nxt.channel_mode    = omode_r;
          out_data_nxt.group_count     = ocount_r;
          out_data_nxt.notes_off_mask  = fail_r ? 16'd0 : mask_r;
          state_nxt                    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ccount_r    <= CHANNEL_COUNT_RST;
      basic_r     <= '0;
      enabled_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        ccount_r <= cfg_pwdata[CNT_W-1:0];
      end
      if (wr_en) begin
        basic_r[k_r[CH_W-1:0]]   <= wr_fill && (k_r[CH_W-1:0] == c_r);
        enabled_r[k_r[CH_W-1:0]] <= wr_fill;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mode_mem[k_r[CH_W-1:0]] <= wr_fill ? opm_r : 2'd0;
      gs_mem[k_r[CH_W-1:0]]   <= (wr_fill && k_r[CH_W-1:0] == c_r) ? size_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    c_r        <= c_nxt;
    opm_r      <= opm_nxt;
    req_r      <= req_nxt;
    allow_r    <= allow_nxt;
    n_r        <= n_nxt;
    size_r     <= size_nxt;
    k_r        <= k_nxt;
    end_r      <= end_nxt;
    basic_c_r  <= basic_c_nxt;
    gs_c_r     <= gs_c_nxt;
    mode_c_r   <= mode_c_nxt;
    fail_r     <= fail_nxt;
    qv_r       <= qv_nxt;
    owner_r    <= owner_nxt;
    omode_r    <= omode_nxt;
    ocount_r   <= ocount_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  `MBCG_ASSERT(a_mask_only_on_ok,
    (out_valid_r && out_data_r.notes_off_mask != 16'd0) |-> !out_data_r.status,
    "notes-off mask on a failed beat")
  `MBCG_ASSERT(a_owner_only_on_ok,
    (out_valid_r && out_data_r.basic_valid) |->
      (!out_data_r.status && out_data_r.notes_off_mask == 16'd0),
    "query answer mixed with failure or mask")
  `MBCG_ASSERT(a_basic_is_enabled, (basic_r & ~enabled_r) == '0, "basic channel not enabled")
  `MBCG_ASSERT(a_walk_in_table,
    (state_r == ST_WRITE || state_r == ST_CLEAR) |->
      (k_r <= CNT_W'(MAX_CHANNELS) && end_r <= CNT_W'(MAX_CHANNELS)),
    "entry walk ran past the table")
  `MBCG_ASSERT(a_done_to_beat,
    (state_r == ST_DONE && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == ST_IDLE),
    "finished item not presented")
  `MBCG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r),
    "reset did not return to idle")

endmodule
